FILE: hdl/vwe_pkg.sv
// Package for the vertex welder: payload structs, register indexes, widths.
package vwe_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned FLAG_W          = 16;
  localparam int unsigned EPS_W           = 31;
  localparam int unsigned INDEX_W         = 10;
  localparam int unsigned LANES           = 5;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_EPSILON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_FLAGS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_TEXELS = 2'd2;

  localparam logic [EPS_W-1:0] EPS_RESET = 31'd66;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic        new_mesh;
    coord_t      pos_x;
    coord_t      pos_y;
    coord_t      pos_z;
    coord_t      tex_u;
    coord_t      tex_v;
    logic [FLAG_W-1:0] vertex_flags;
  } in_data_t;

  typedef struct packed {
    logic [INDEX_W-1:0] welded_index;
    logic               is_duplicate;
    logic               table_full;
  } out_data_t;

  // One stored vertex: lane 0..4 = x, y, z, u, v
  typedef struct packed {
    coord_t [LANES-1:0] crd;
    logic [FLAG_W-1:0]  flags;
  } entry_t;

  // What one compare cell hands to the next
  typedef struct packed {
    logic               valid;
    logic               match;
    coord_t [LANES-1:0] crd;
  } link_t;

endpackage

FILE: hdl/vwe_store.sv
// Unique-vertex table: one write port, one registered read port.
module vwe_store
  import vwe_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/vwe_cell.sv
// Compare cell: checks one coordinate lane within epsilon, passes the rest on.
module vwe_cell
  import vwe_pkg::*;
#(
  parameter int unsigned LANE = 0,
  parameter int unsigned AW   = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush,
  input  logic             en,
  input  logic [EPS_W-1:0] eps,
  input  coord_t           vtx,
  input  link_t            lnk_in,
  input  logic [AW-1:0]    idx_in,
  output link_t            lnk_out,
  output logic [AW-1:0]    idx_out
);

  logic signed [COORD_W:0] diff;
  logic signed [COORD_W:0] epsx;
  logic                    in_eps;
  logic                    valid_r;
  logic                    match_r;
  coord_t [LANES-1:0]      crd_r;
  logic [AW-1:0]           idx_r;

  assign diff   = {vtx[COORD_W-1], vtx} - {lnk_in.crd[LANE][COORD_W-1], lnk_in.crd[LANE]};
  assign epsx   = {2'b00, eps};
  assign in_eps = (diff <= epsx) && (diff >= -epsx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= lnk_in.valid & ~flush;
    end
    match_r <= lnk_in.match & (~en | in_eps);
    crd_r   <= lnk_in.crd;
    idx_r   <= idx_in;
  end

  assign lnk_out.valid = valid_r;
  assign lnk_out.match = match_r;
  assign lnk_out.crd   = crd_r;
  assign idx_out       = idx_r;

endmodule

FILE: hdl/vertex_weld_epsilon.sv
// Top level of the epsilon vertex welder: scan sequencer, table and compare chain.
// Scan: each vertex is compared against the stored entries from the newest down to entry
// zero through the compare chain; a duplicate ends the scan early, an empty table skips it.
// Throughput: one vertex at a time, one table entry per cycle; a new transaction is taken
// the cycle after the result registers, held off while the output stalls.
// Reset (synchronous, rst_n low): table emptied, registers back to epsilon 66 and
// both compare enables off; table contents are not cleared, only the count.
module vertex_weld_epsilon
  import vwe_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_data_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_data_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EPS_W-1:0]     cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // configuration
  logic [EPS_W-1:0] eps_r;
  logic             cmp_flags_r;
  logic             cmp_texels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r        <= EPS_RESET;
      cmp_flags_r  <= 1'b0;
      cmp_texels_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_EPSILON:  eps_r        <= cfg_wdata;
        REG_COMPARE_FLAGS:  cmp_flags_r  <= cfg_wdata[0];
        REG_COMPARE_TEXELS: cmp_texels_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          issuing_r, issuing_nxt;
  logic          rd_valid_r;
  logic [AW-1:0] rd_idx_r;
  logic          found_r, found_nxt;
  logic [AW-1:0] found_idx_r, found_idx_nxt;
  in_data_t      vtx_r;
  logic          out_valid_r, out_valid_nxt;
  out_data_t     out_data_r, out_data_nxt;

  entry_t        rd_data;
  entry_t        wr_data;
  logic          wr_en;
  logic          accept;
  logic          hit;
  logic          last;
  logic          flush;
  logic          out_free;
  logic [CW-1:0] count_eff;

  link_t         lnk [LANES+1];
  logic [AW-1:0] lidx [LANES+1];
  coord_t [LANES-1:0] vcrd;

  assign accept   = in_valid & in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = ~out_valid_r | out_ready;
  assign count_eff = in_data.new_mesh ? '0 : count_r;

  assign vcrd = {vtx_r.tex_v, vtx_r.tex_u, vtx_r.pos_z, vtx_r.pos_y, vtx_r.pos_x};

  // end of chain: first match in descending order wins, flush the rest
  assign hit   = (state_r == ST_SCAN) && lnk[LANES].valid && lnk[LANES].match && !found_r;
  assign last  = (state_r == ST_SCAN) && lnk[LANES].valid && (lidx[LANES] == '0);
  assign flush = hit;

  // store only on a miss with room left
  assign wr_en   = (state_r == ST_FINISH) && out_free && !found_r &&
                   (count_r < CW'(TABLE_DEPTH));
  assign wr_data.crd   = vcrd;
  assign wr_data.flags = vtx_r.vertex_flags;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_addr_nxt   = rd_addr_r;
    issuing_nxt   = issuing_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = count_eff;
          found_nxt = 1'b0;
          if (count_eff == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            rd_addr_nxt = AW'(count_eff - CW'(1));
            issuing_nxt = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // advance the read address down to entry zero
        if (flush) begin
          issuing_nxt = 1'b0;
        end else if (issuing_r) begin
          if (rd_addr_r == '0) begin
            issuing_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r - AW'(1);
          end
        end
        if (hit) begin
          found_nxt     = 1'b1;
          found_idx_nxt = lidx[LANES];
          state_nxt     = ST_FINISH;
        end else if (last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_data_nxt.welded_index = INDEX_W'(found_idx_r);
            out_data_nxt.is_duplicate = 1'b1;
            out_data_nxt.table_full   = 1'b0;
          end else if (count_r < CW'(TABLE_DEPTH)) begin
            out_data_nxt.welded_index = INDEX_W'(count_r);
            out_data_nxt.is_duplicate = 1'b0;
            out_data_nxt.table_full   = 1'b0;
            count_nxt                 = count_r + CW'(1);
          end else begin
            out_data_nxt.welded_index = INDEX_W'(TABLE_DEPTH - 1);
            out_data_nxt.is_duplicate = 1'b0;
            out_data_nxt.table_full   = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issuing_r   <= 1'b0;
      rd_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issuing_r   <= issuing_nxt;
      rd_valid_r  <= issuing_r & ~flush;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r   <= rd_addr_nxt;
    rd_idx_r    <= rd_addr_r;
    found_idx_r <= found_idx_nxt;
    out_data_r  <= out_data_nxt;
    if (accept) begin
      vtx_r <= in_data;
    end
  end

  vwe_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count_r)),
    .wr_data (wr_data),
    .rd_en   (issuing_r),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // head of the chain: flag word check folds in before the coordinate lanes
  assign lnk[0].valid = rd_valid_r;
  assign lnk[0].match = ~cmp_flags_r | (rd_data.flags == vtx_r.vertex_flags);
  assign lnk[0].crd   = rd_data.crd;
  assign lidx[0]      = rd_idx_r;

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    vwe_cell #(
      .LANE (g),
      .AW   (AW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .flush   (flush),
      .en      ((g >= 3) ? cmp_texels_r : 1'b1),
      .eps     (eps_r),
      .vtx     (vcrd[g]),
      .lnk_in  (lnk[g]),
      .idx_in  (lidx[g]),
      .lnk_out (lnk[g+1]),
      .idx_out (lidx[g+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("unique count above table depth");

  a_chain_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    lnk[LANES].valid |-> (state_r == ST_SCAN))
    else $error("compare result outside a scan");

  a_dup_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.is_duplicate && out_data_r.table_full))
    else $error("result both duplicate and full");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (count_r == $past(count_r) + CW'(1)))
    else $error("table write without count advance");

endmodule
